@@ sv/kdlp_pkg.sv @@
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants for the key debounce and long-press unit.
// ----------------------------------------------------------------------------
package kdlp_pkg;

  localparam int unsigned TIME_W  = 64;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned KSEL_W  = 2;
  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned EVT_W   = 3;

  localparam logic [EVT_W-1:0] EVT_NONE = 3'd0;
  localparam logic [EVT_W-1:0] EVT_LONG = 3'd5;

  localparam logic [MS_W-1:0]   DEBOUNCE_RST  = 16'd30;
  localparam logic [MS_W-1:0]   LONG_MS_RST   = 16'd800;
  localparam logic [KSEL_W-1:0] LONG_KEY_RST  = 2'd1;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_LONG_MS  = 2'd1;
  localparam logic [1:0] REG_LONG_KEY = 2'd2;

  typedef struct packed {
    logic              raw;
    logic              stable;
    logic              fired;
    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] press_time;
  } key_state_t;

  typedef struct packed {
    logic short_hit;
    logic long_hit;
  } lane_evt_t;

endpackage

@@ sv/kdlp_lane.sv @@
// ----------------------------------------------------------------------------
// kdlp_lane
// Per-key debounce, press timing and long-press detection for one word.
// ----------------------------------------------------------------------------
module kdlp_lane #(
  parameter int unsigned LANE_IDX = 0
) (
  input  logic [kdlp_pkg::TIME_W-1:0] now_i,
  input  logic                        down_i,
  input  logic [kdlp_pkg::MS_W-1:0]   debounce_i,
  input  logic [kdlp_pkg::MS_W-1:0]   long_ms_i,
  input  logic [kdlp_pkg::KSEL_W-1:0] long_key_i,
  input  kdlp_pkg::key_state_t        state_i,
  output kdlp_pkg::key_state_t        state_o,
  output kdlp_pkg::lane_evt_t         evt_o
);
  import kdlp_pkg::*;

  logic              changed;
  logic              accept;
  logic              press_acc;
  logic              fired_mid;
  logic              is_long_key;
  logic              deb_ok;
  logic              long_ok;
  logic [TIME_W-1:0] el_change;
  logic [TIME_W-1:0] el_press;

  assign changed   = down_i != state_i.raw;
  assign el_change = changed ? '0 : (now_i - state_i.change_time);
  assign deb_ok    = (el_change[TIME_W-1:MS_W] != '0) || (el_change[MS_W-1:0] >= debounce_i);
  assign accept    = deb_ok && (down_i != state_i.stable);
  assign press_acc = accept && down_i;
  assign fired_mid = press_acc ? 1'b0 : state_i.fired;
  assign el_press  = press_acc ? '0 : (now_i - state_i.press_time);
  assign long_ok   = (el_press[TIME_W-1:MS_W] != '0) || (el_press[MS_W-1:0] >= long_ms_i);

  if (LANE_IDX < (1 << KSEL_W)) begin : g_sel
    assign is_long_key = long_key_i == LANE_IDX[KSEL_W-1:0];
  end else begin : g_nosel
    assign is_long_key = 1'b0;
  end

  always_comb begin
    evt_o.short_hit = accept && !down_i && !state_i.fired;
    evt_o.long_hit  = !evt_o.short_hit && is_long_key && (accept ? down_i : state_i.stable) &&
                      !fired_mid && long_ok;
    state_o.raw         = down_i;
    state_o.change_time = changed ? now_i : state_i.change_time;
    state_o.stable      = accept ? down_i : state_i.stable;
    state_o.press_time  = press_acc ? now_i : state_i.press_time;
    state_o.fired       = evt_o.long_hit ? 1'b1 : fired_mid;
  end

endmodule

@@ sv/kdlp_merge.sv @@
// ----------------------------------------------------------------------------
// kdlp_merge
// Pick the lowest key with an event, form its code and the commit mask.
// ----------------------------------------------------------------------------
module kdlp_merge #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  kdlp_pkg::lane_evt_t         evt_i [NUM_KEYS],
  output logic [NUM_KEYS-1:0]         commit_o,
  output logic [kdlp_pkg::EVT_W-1:0]  code_o
);
  import kdlp_pkg::*;

  logic found;

  always_comb begin
    found    = 1'b0;
    code_o   = EVT_NONE;
    commit_o = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      commit_o[i] = !found;
      if (!found && evt_i[i].short_hit) begin
        code_o = EVT_W'(i + 1);
        found  = 1'b1;
      end else if (!found && evt_i[i].long_hit) begin
        code_o = EVT_LONG;
        found  = 1'b1;
      end
    end
  end

endmodule

@@ sv/key_debounce_long_press_unit.sv @@
// ----------------------------------------------------------------------------
// key_debounce_long_press_unit
// Debounces active-low keys and reports short and long presses per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries a word of now_ms_i and
//   key_levels_i. Each accepted word yields exactly one output word on
//   out_valid_o/out_ready_i with event_res_o (0 none, 1..4 short press of
//   key 0..3, 5 long press).
//   The result is registered at the edge that accepts the word. Throughput
//   is one word per cycle unless the output stalls; all keys are evaluated in
//   parallel lanes and the lowest key with an event wins in one merge step.
//   in_ready_o stays high while the output register is empty or being
//   drained, so a stalled receiver holds back at most one pending result.
//   The APB port sets debounce time, long-press time and long-press key at
//   byte addresses 0, 4 and 8; pready is always high.
//   Reset clears all key state and loads the default register values.
// ----------------------------------------------------------------------------
module key_debounce_long_press_unit #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kdlp_pkg::TIME_W-1:0]   now_ms_i,
  input  logic [kdlp_pkg::LEVEL_W-1:0]  key_levels_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kdlp_pkg::EVT_W-1:0]    event_res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import kdlp_pkg::*;

  logic [MS_W-1:0]   debounce_q;
  logic [MS_W-1:0]   long_ms_q;
  logic [KSEL_W-1:0] long_key_q;
  logic              cfg_we;

  key_state_t        state_q [NUM_KEYS];
  key_state_t        state_d [NUM_KEYS];
  lane_evt_t         evt     [NUM_KEYS];
  logic [NUM_KEYS-1:0] commit;
  logic [EVT_W-1:0]  code;

  logic              out_valid_q;
  logic              out_valid_d;
  logic [EVT_W-1:0]  event_q;
  logic              in_fire;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_DEBOUNCE: prdata = {16'd0, debounce_q};
      REG_LONG_MS:  prdata = {16'd0, long_ms_q};
      REG_LONG_KEY: prdata = {30'd0, long_key_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      long_ms_q  <= LONG_MS_RST;
      long_key_q <= LONG_KEY_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_DEBOUNCE: debounce_q <= pwdata[MS_W-1:0];
        REG_LONG_MS:  long_ms_q  <= pwdata[MS_W-1:0];
        REG_LONG_KEY: long_key_q <= pwdata[KSEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic down;
    if (k < LEVEL_W) begin : g_pin
      assign down = !key_levels_i[k];
    end else begin : g_nopin
      assign down = 1'b0;
    end

    kdlp_lane #(
      .LANE_IDX (k)
    ) u_lane (
      .now_i      (now_ms_i),
      .down_i     (down),
      .debounce_i (debounce_q),
      .long_ms_i  (long_ms_q),
      .long_key_i (long_key_q),
      .state_i    (state_q[k]),
      .state_o    (state_d[k]),
      .evt_o      (evt[k])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        state_q[k] <= '0;
      end else if (in_fire && commit[k]) begin
        state_q[k] <= state_d[k];
      end
    end
  end

  kdlp_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .evt_i    (evt),
    .commit_o (commit),
    .code_o   (code)
  );

  assign out_valid_d = in_fire ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      event_q <= code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = event_q;

endmodule

@@ test/kdlp_event_checker.sv @@
// ----------------------------------------------------------------------------
// kdlp_event_checker
// Watches the input, output and APB channels of the key debounce unit. Keeps
// its own copy of the key state and register values, predicts the event of
// every accepted input word, and compares it with the output words in order.
// ----------------------------------------------------------------------------
module kdlp_event_checker #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [kdlp_pkg::TIME_W-1:0]   now_ms_i,
  input  logic [kdlp_pkg::LEVEL_W-1:0]  key_levels_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [kdlp_pkg::EVT_W-1:0]    event_res_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [3:0]                    paddr_i,
  input  logic [31:0]                   pwdata_i,
  input  logic                          pready_i,
  output int unsigned                   fail_cnt_o,
  output int unsigned                   pending_o
);
  import kdlp_pkg::*;

  logic [MS_W-1:0]   debounce_ms;
  logic [MS_W-1:0]   long_ms;
  logic [KSEL_W-1:0] long_key;

  logic              key_raw       [NUM_KEYS];
  logic              key_stable    [NUM_KEYS];
  logic              key_fired     [NUM_KEYS];
  logic [TIME_W-1:0] key_change_ms [NUM_KEYS];
  logic [TIME_W-1:0] key_press_ms  [NUM_KEYS];

  logic [EVT_W-1:0]  events_due_q[$];
  int unsigned       fail_cnt;

  function automatic logic [EVT_W-1:0] next_event(input logic [TIME_W-1:0]  now,
                                                  input logic [LEVEL_W-1:0] levels);
    logic [EVT_W-1:0] evt;
    logic             down;
    logic             stop;
    evt  = EVT_NONE;
    stop = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (!stop) begin
        down = (k < LEVEL_W) ? !levels[k] : 1'b0;
        if (down != key_raw[k]) begin
          key_raw[k]       = down;
          key_change_ms[k] = now;
        end
        if ((now - key_change_ms[k]) >= TIME_W'(debounce_ms) &&
            key_raw[k] != key_stable[k]) begin
          key_stable[k] = key_raw[k];
          if (key_stable[k]) begin
            key_press_ms[k] = now;
            key_fired[k]    = 1'b0;
          end else if (!key_fired[k]) begin
            evt  = EVT_W'(k + 1);
            stop = 1'b1;
          end
        end
        if (!stop && k == int'(long_key) && key_stable[k] && !key_fired[k] &&
            (now - key_press_ms[k]) >= TIME_W'(long_ms)) begin
          key_fired[k] = 1'b1;
          evt          = EVT_LONG;
          stop         = 1'b1;
        end
      end
    end
    return evt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [EVT_W-1:0] want;
    if (!rst_ni) begin
      debounce_ms = DEBOUNCE_RST;
      long_ms     = LONG_MS_RST;
      long_key    = LONG_KEY_RST;
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_raw[k]       = 1'b0;
        key_stable[k]    = 1'b0;
        key_fired[k]     = 1'b0;
        key_change_ms[k] = '0;
        key_press_ms[k]  = '0;
      end
      events_due_q.delete();
      fail_cnt = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_DEBOUNCE: debounce_ms = pwdata_i[MS_W-1:0];
          REG_LONG_MS:  long_ms     = pwdata_i[MS_W-1:0];
          REG_LONG_KEY: long_key    = pwdata_i[KSEL_W-1:0];
          default: ;
        endcase
      end
      // retire the output word first: it belongs to an earlier input word
      if (out_valid_i && out_ready_i) begin
        if (events_due_q.size() == 0) begin
          $error("event_res: unexpected word, expected none, actual %0d", event_res_i);
          fail_cnt++;
        end else begin
          want = events_due_q.pop_front();
          if (event_res_i !== want) begin
            $error("event_res mismatch: expected %0d, actual %0d", want, event_res_i);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        events_due_q.push_back(next_event(now_ms_i, key_levels_i));
      fail_cnt_o <= fail_cnt;
      pending_o  <= events_due_q.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the key debounce and long-press unit with directed key sequences
// and randomized press, hold, bounce and release gestures under several
// register settings, with random idling on both channels and one long
// receiver hold-off. The checker beside the block predicts every event.
// ----------------------------------------------------------------------------
module tb_top;
  import kdlp_pkg::*;

  localparam int unsigned NUM_KEYS        = 4;
  localparam int unsigned PHASE_WORDS     = 100;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [TIME_W-1:0]   now_ms     = '0;
  logic [LEVEL_W-1:0]  key_levels = '1;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [EVT_W-1:0]    event_res;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [3:0]          paddr      = '0;
  logic [31:0]         pwdata     = '0;
  logic [31:0]         prdata;
  logic                pready;

  int unsigned         fail_cnt;
  int unsigned         pending;
  int unsigned         cycle_cnt;
  int unsigned         words_sent = 0;
  int unsigned         cfg_db     = 32'(DEBOUNCE_RST);
  int unsigned         cfg_long   = 32'(LONG_MS_RST);
  bit                  tx_idle_on = 1'b1;
  bit                  rx_idle_on = 1'b1;
  logic                hold_off_req = 1'b0;
  logic [TIME_W-1:0]   now_t;
  logic [LEVEL_W-1:0]  key_lv;

  key_debounce_long_press_unit #(.NUM_KEYS(NUM_KEYS)) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .now_ms_i     (now_ms),
    .key_levels_i (key_levels),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .event_res_o  (event_res),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  kdlp_event_checker #(.NUM_KEYS(NUM_KEYS)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .now_ms_i     (now_ms),
    .key_levels_i (key_levels),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .event_res_i  (event_res),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_word(input logic [TIME_W-1:0] t, input logic [LEVEL_W-1:0] lv);
    if (tx_idle_on && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 29);
    end
    in_valid   <= 1'b1;
    now_ms     <= t;
    key_levels <= lv;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned db, input int unsigned lg, input int unsigned key);
    apb_write(REG_DEBOUNCE, 32'(db));
    apb_write(REG_LONG_MS,  32'(lg));
    apb_write(REG_LONG_KEY, 32'(key));
    cfg_db   = db;
    cfg_long = lg;
  endtask

  function automatic logic [TIME_W-1:0] pick_step();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return TIME_W'($urandom_range(0, cfg_db));
    if (r < 85) return TIME_W'(cfg_db + $urandom_range(0, cfg_long / 2 + 1));
    return TIME_W'($urandom_range(0, 2 * cfg_long + cfg_db + 2));
  endfunction

  // bounce, press, hold, bounce, release on one or more keys
  task automatic key_gesture();
    logic [LEVEL_W-1:0] mask;
    int unsigned        n;
    if ($urandom_range(1)) mask = LEVEL_W'(1) << $urandom_range(0, LEVEL_W - 1);
    else                   mask = LEVEL_W'($urandom_range(1, 15));
    n = $urandom_range(0, 3);
    repeat (n) begin
      now_t += TIME_W'($urandom_range(0, cfg_db / 2));
      send_word(now_t, key_lv ^ (mask & LEVEL_W'($urandom)));
    end
    key_lv &= ~mask;
    n = $urandom_range(1, 6);
    repeat (n) begin
      now_t += pick_step();
      send_word(now_t, key_lv);
    end
    n = $urandom_range(0, 3);
    repeat (n) begin
      now_t += TIME_W'($urandom_range(0, cfg_db / 2));
      send_word(now_t, key_lv ^ (mask & LEVEL_W'($urandom)));
    end
    key_lv |= mask;
    n = $urandom_range(1, 4);
    repeat (n) begin
      now_t += pick_step();
      send_word(now_t, key_lv);
    end
  endtask

  task automatic noise_word();
    case ($urandom_range(3))
      0:       now_t = {$urandom, $urandom};
      1:       now_t -= TIME_W'($urandom_range(0, 2 * cfg_db + 2));
      default: now_t += pick_step();
    endcase
    key_lv = LEVEL_W'($urandom);
    send_word(now_t, key_lv);
  endtask

  task automatic run_phase(input int unsigned db, input int unsigned lg, input int unsigned key,
                           input bit idle, input bit squeeze);
    int unsigned goal;
    set_config(db, lg, key);
    tx_idle_on = idle;
    rx_idle_on = idle;
    if (squeeze) hold_off_req <= 1'b1;
    goal = words_sent + PHASE_WORDS;
    while (words_sent < goal) begin
      if ($urandom_range(99) < 75) key_gesture();
      else                         noise_word();
    end
    drain();
  endtask

  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= !rx_idle_on || ($urandom_range(99) >= 29);
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short press of key 0, long press of key 1 under reset values
    send_word(64'd0,    4'hF);
    send_word(64'd5,    4'hE);
    send_word(64'd40,   4'hE);
    send_word(64'd50,   4'hF);
    send_word(64'd80,   4'hF);
    send_word(64'd100,  4'hD);
    send_word(64'd130,  4'hD);
    send_word(64'd930,  4'hD);
    send_word(64'd940,  4'hF);
    send_word(64'd970,  4'hF);
    // all keys at once: releases come out one key per word
    send_word(64'd1000, 4'h0);
    send_word(64'd1030, 4'h0);
    send_word(64'd1040, 4'hF);
    send_word(64'd1070, 4'hF);
    send_word(64'd1071, 4'hF);
    send_word(64'd1072, 4'hF);
    send_word(64'd1073, 4'hF);
    // time running backwards and across the wrap
    send_word(64'd2000, 4'hE);
    send_word(64'd10,   4'hE);
    send_word('1,       4'hF);
    send_word(64'd0,    4'hF);
    send_word(64'h8000_0000_0000_0000, 4'hF);
    drain();

    // zero debounce and zero hold time
    set_config(0, 0, 2);
    send_word(64'd1, 4'hB);
    send_word(64'd2, 4'hF);
    send_word(64'd3, 4'hE);
    send_word(64'd3, 4'hF);
    drain();

    now_t  = 64'd5000;
    key_lv = '1;
    run_phase(32'(DEBOUNCE_RST), 32'(LONG_MS_RST), 32'(LONG_KEY_RST), 1'b1, 1'b0);
    run_phase(0, 0, 0, 1'b1, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 3, 1'b1, 1'b0);
    run_phase($urandom_range(0, 60), $urandom_range(0, 300), $urandom_range(0, 3), 1'b0, 1'b0);
    run_phase($urandom_range(0, 60), $urandom_range(0, 300), $urandom_range(0, 3), 1'b1, 1'b1);
    run_phase(1, 1, 2, 1'b1, 1'b0);

    repeat (8) @(posedge clk);
    if (fail_cnt == 0) $display("*** PASSED ***");
    else               $display("*** FAILED ***");
    $finish;
  end

endmodule
